[rtl/core/gelu_tanh_activation_assert.svh]
// Assertion macros for the GELU activation block.
// Both macros sample on the rising edge of clock and are switched off while reset is high.
`ifndef GELU_TANH_ACTIVATION_ASSERT_SVH
`define GELU_TANH_ACTIVATION_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define GTA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The condition must hold in the cycle after the trigger.
`define GTA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/gta_pkg.sv]
// Shared types and constants for the GELU activation block.
// This file has no dependencies. The series cell, the divider cell and the top module import it.
`timescale 1ns / 1ps

package gta_pkg;

   // 1.0 in the Q30 format that is used inside the tanh evaluation.
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

   // sqrt(2/pi) and 0.044715 in Q30.
   localparam logic [29:0] COEF_SQRT2PI = 30'd856722023;
   localparam logic [25:0] COEF_CUBIC   = 26'd48012366;

   // Gain after reset: 1.0 at twelve fraction bits.
   localparam logic [63:0] GAIN_RESET = 64'd4096;

   // Shape of the tanh datapath.
   localparam int unsigned HORNER_TERMS = 10;
   localparam int unsigned HORNER_LAT   = 2;
   localparam int unsigned SQUARINGS    = 4;
   localparam int unsigned DIV_STEPS    = 31;

   // Data handed from one series cell to the next.
   typedef struct packed {
      logic [29:0] arg;
      logic [30:0] acc;
   } gta_hrn_type;

   // Data handed from one divider cell to the next.
   typedef struct packed {
      logic [31:0] den;
      logic [30:0] rem;
      logic [30:0] quo;
      logic        nxt;
   } gta_div_type;

endpackage

[rtl/core/gta_req_if.sv]
// Input channel of the GELU activation block: valid/ready handshake with one sample.
// No dependencies.
`timescale 1ns / 1ps

interface gta_req_if #(
   parameter int DATA_WIDTH = 16
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

[rtl/core/gta_rsp_if.sv]
// Result channel of the GELU activation block: valid/ready handshake with one sample.
// No dependencies.
`timescale 1ns / 1ps

interface gta_rsp_if #(
   parameter int DATA_WIDTH = 16
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

[rtl/core/gta_horner_cell.sv]
// One cell of the exponential series chain: acc = 1 - (arg * acc) / DIVISOR, all in Q30.
// Depends on gta_pkg. Two register stages per cell.
`timescale 1ns / 1ps

module gta_horner_cell
   import gta_pkg::*;
#(
   parameter int unsigned DIVISOR = 1
) (
   input  logic        clock,
   input  logic        adv,
   input  gta_hrn_type link_prev,
   output gta_hrn_type link_next
);

   logic [60:0]  prod_full;
   logic [29:0]  prod_ff, prod_in;
   logic [29:0]  lead_arg_ff;
   logic [29:0]  quot;
   gta_hrn_type  stage_ff, stage_in;

   // First stage: product of the argument and the running sum, back to Q30.
   assign prod_full = link_prev.arg * link_prev.acc;
   assign prod_in   = prod_full[59:30];

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff     <= prod_in;
         lead_arg_ff <= link_prev.arg;
      end
   end

   // Second stage: exact floor division by the cell's constant divisor.
   generate
      if ((DIVISOR & (DIVISOR - 1)) == 0) begin : g_shift
         localparam int unsigned SHIFT = $clog2(DIVISOR);
         assign quot = prod_ff >> SHIFT;
      end else begin : g_recip
         // ceil(2^34 / DIVISOR) makes the product exact for every 30-bit dividend.
         localparam logic [34:0] RECIP =
            35'(((64'd1 << 34) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
         logic [62:0] quot_full;
         assign quot_full = prod_ff * RECIP[32:0];
         assign quot      = {1'b0, quot_full[62:34]};
      end
   endgenerate

   always_comb begin
      stage_in.arg = lead_arg_ff;
      stage_in.acc = ONE_Q30[30:0] - {1'b0, quot};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign link_next = stage_ff;

endmodule

[rtl/core/gta_div_cell.sv]
// One cell of the restoring divider chain: produces one quotient bit per cell.
// Depends on gta_pkg. One register stage per cell.
`timescale 1ns / 1ps

module gta_div_cell
   import gta_pkg::*;
(
   input  logic        clock,
   input  logic        adv,
   input  gta_div_type link_prev,
   output gta_div_type link_next
);

   logic [31:0] trial;
   logic [31:0] diff;
   logic        fits;
   gta_div_type stage_ff, stage_in;

   // Bring down the next dividend bit and try to subtract the divisor.
   assign trial = {link_prev.rem, link_prev.nxt};
   assign fits  = trial >= link_prev.den;
   assign diff  = trial - link_prev.den;

   always_comb begin
      stage_in.den = link_prev.den;
      stage_in.rem = fits ? diff[30:0] : trial[30:0];
      stage_in.quo = {link_prev.quo[29:0], fits};
      stage_in.nxt = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign link_next = stage_ff;

endmodule

[rtl/core/gelu_tanh_activation.sv]
// GELU activation, tanh form: y = gain * 0.5 * x * (1 + tanh(sqrt(2/pi)*(x + 0.044715*x^3))).
// Depends on gta_pkg, gta_req_if, gta_rsp_if, gta_horner_cell, gta_div_cell and the macro header.
// Samples arrive on req_port and results leave on rsp_port, both valid/ready channels in
// signed fixed point with FRAC_BITS fraction bits. A transfer happens when valid and ready
// are both high. The gain must be written through csr_wr_en/csr_wr_data by the user only while
// the block is idle; the block itself does not enforce this. One sample is taken every cycle
// while the skid register is empty, and one result leaves every cycle the receiver is ready.
// Each sample passes six stages that form the tanh argument, ten series cells of two stages
// each, four squaring stages, one divider set-up stage, 31 divider cells (one quotient bit
// each) and three stages for the final products and rounding, then the output register.
// When the receiver stalls, the output register holds its result and a skid register takes
// the next one; once the skid register is full, req_port.ready falls and the whole pipeline
// holds. Reset empties the pipeline and the output registers and sets the gain to 1.0.
`timescale 1ns / 1ps
`include "gelu_tanh_activation_assert.svh"

module gelu_tanh_activation
   import gta_pkg::*;
#(
   parameter int FRAC_BITS  = 12,
   parameter int DATA_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   gta_req_if.sink               req_port,
   gta_rsp_if.source             rsp_port,
   input  logic                  csr_wr_en,
   input  logic [DATA_WIDTH-1:0] csr_wr_data
);

   // Stage numbering along the pipeline.
   localparam int unsigned FRONT_STAGES = 6;
   localparam int unsigned SQR_BASE     = FRONT_STAGES + HORNER_TERMS * HORNER_LAT;
   localparam int unsigned PREP_STAGE   = SQR_BASE + SQUARINGS;
   localparam int unsigned DIV_BASE     = PREP_STAGE + 1;
   localparam int unsigned H_STAGE      = DIV_BASE + DIV_STEPS;
   localparam int unsigned G_STAGE      = H_STAGE + 1;
   localparam int unsigned Y_STAGE      = G_STAGE + 1;
   localparam int unsigned NSTAGE       = Y_STAGE + 1;

   localparam logic [63:0]             BIG_LIMIT = 64'd4 << FRAC_BITS;
   localparam logic [DATA_WIDTH+32:0]  G_ROUND   = (DATA_WIDTH+33)'(ONE_Q30);
   localparam logic [2*DATA_WIDTH:0]   Y_HALF    = (2*DATA_WIDTH+1)'(1) << (FRAC_BITS - 1);
   localparam logic [2*DATA_WIDTH:0]   Y_NEG_LIM = (2*DATA_WIDTH+1)'(1) << (DATA_WIDTH - 1);
   localparam logic [2*DATA_WIDTH:0]   Y_POS_LIM = Y_NEG_LIM - 1'b1;

   // Per-stage item tag: valid, sign, large-sample flag and magnitude of the sample.
   typedef struct packed {
      logic                  valid;
      logic                  xneg;
      logic                  big;
      logic [DATA_WIDTH-1:0] mag;
   } side_type;

   logic                    pipe_adv;
   side_type                side_in;
   side_type                side_ff [0:NSTAGE-1];
   logic [DATA_WIDTH-1:0]   x_raw;
   logic [63:0]             q_wide;

   logic [DATA_WIDTH-1:0]   gain_ff;
   logic                    gain_neg;
   logic [DATA_WIDTH-1:0]   gain_mag;

   logic [31:0]             q1_ff, q1_in, q2_ff, q3_ff, q4_ff;
   logic [63:0]             s_full;
   logic [33:0]             s2_ff;
   logic [63:0]             c_full;
   logic [35:0]             c3_ff;
   logic [61:0]             k_full;
   logic [31:0]             k4_ff;
   logic [32:0]             w5_ff, w5_in;
   logic [62:0]             u_full;
   logic [29:0]             b6_ff;

   gta_hrn_type             hrn_link [0:HORNER_TERMS];
   logic [30:0]             sq_ff [0:SQUARINGS-1];
   gta_div_type             div0_ff, div0_in;
   gta_div_type             div_link [0:DIV_STEPS];
   logic [30:0]             prep_x;

   logic [30:0]             t_sel;
   logic [31:0]             h_ff, h_in;
   logic [DATA_WIDTH+31:0]  g_mul;
   logic [DATA_WIDTH+32:0]  g_sum;
   logic [DATA_WIDTH-1:0]   g_ff;
   logic [2*DATA_WIDTH-1:0] y_mul;
   logic [2*DATA_WIDTH:0]   y_sum;
   logic [2*DATA_WIDTH:0]   y_ff, y_in;
   logic                    yneg_ff, yneg_in;
   logic [DATA_WIDTH-1:0]   y_neg_mag;
   logic [DATA_WIDTH-1:0]   out_word;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]   rsp_data_ff, rsp_data_in;
   logic                    skid_valid_ff, skid_valid_in;
   logic [DATA_WIDTH-1:0]   skid_data_ff, skid_data_in;
   logic                    rsp_take;

   // The pipeline moves whenever the skid register is free.
   assign pipe_adv       = !skid_valid_ff;
   assign req_port.ready = pipe_adv;

   // Gain register.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= DATA_WIDTH'(GAIN_RESET);
      end else if (csr_wr_en) begin
         gain_ff <= csr_wr_data;
      end
   end

   assign gain_neg = gain_ff[DATA_WIDTH-1];
   assign gain_mag = gain_neg ? DATA_WIDTH'(~gain_ff + 1'b1) : gain_ff;

   // Input stage: sign, magnitude and the argument in Q30.
   always_comb begin
      x_raw         = req_port.sample_in;
      side_in.valid = req_port.valid;
      side_in.xneg  = x_raw[DATA_WIDTH-1];
      side_in.mag   = side_in.xneg ? DATA_WIDTH'(~x_raw + 1'b1) : x_raw;
      side_in.big   = 64'(side_in.mag) >= BIG_LIMIT;
      q_wide        = 64'(side_in.mag) << (30 - FRAC_BITS);
      q1_in         = q_wide[31:0];
   end

   // Tag shift line that follows every item down the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTAGE; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else if (pipe_adv) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < NSTAGE; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Argument of tanh: sqrt(2/pi) * (q + 0.044715 q^3), then b = 2u/16.
   assign s_full = q1_ff * q1_ff;
   assign c_full = s2_ff * q2_ff[31:2];
   assign k_full = COEF_CUBIC * c3_ff;
   assign w5_in  = {1'b0, q4_ff} + {1'b0, k4_ff};
   assign u_full = COEF_SQRT2PI * w5_ff;

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         q1_ff <= q1_in;
         s2_ff <= s_full[63:30];
         q2_ff <= q1_ff;
         c3_ff <= c_full[63:28];
         q3_ff <= q2_ff;
         k4_ff <= k_full[61:30];
         q4_ff <= q3_ff;
         w5_ff <= w5_in;
         b6_ff <= u_full[62:33];
      end
   end

   // Series chain for e^-b, highest-order term first.
   assign hrn_link[0].arg = b6_ff;
   assign hrn_link[0].acc = ONE_Q30[30:0];

   generate
      for (genvar j = 0; j < HORNER_TERMS; j++) begin : g_hrn
         gta_horner_cell #(
            .DIVISOR (HORNER_TERMS - j)
         ) u_cell (
            .clock     (clock),
            .adv       (pipe_adv),
            .link_prev (hrn_link[j]),
            .link_next (hrn_link[j+1])
         );
      end
   endgenerate

   // Four squarings raise e^-b to e^-2u.
   generate
      for (genvar i = 0; i < SQUARINGS; i++) begin : g_sqr
         logic [30:0] sq_src;
         logic [61:0] sq_full;
         if (i == 0) begin : g_first
            assign sq_src = hrn_link[HORNER_TERMS].acc;
         end else begin : g_rest
            assign sq_src = sq_ff[i-1];
         end
         assign sq_full = sq_src * sq_src;
         always_ff @(posedge clock) begin
            if (pipe_adv) begin
               sq_ff[i] <= sq_full[60:30];
            end
         end
      end
   endgenerate

   // Divider set-up for (1 - e) * 2^30 / (1 + e).
   always_comb begin
      prep_x      = ONE_Q30[30:0] - sq_ff[SQUARINGS-1];
      div0_in.den = ONE_Q30 + {1'b0, sq_ff[SQUARINGS-1]};
      div0_in.rem = {1'b0, prep_x[30:1]};
      div0_in.quo = '0;
      div0_in.nxt = prep_x[0];
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         div0_ff <= div0_in;
      end
   end

   assign div_link[0] = div0_ff;

   generate
      for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
         gta_div_cell u_cell (
            .clock     (clock),
            .adv       (pipe_adv),
            .link_prev (div_link[i]),
            .link_next (div_link[i+1])
         );
      end
   endgenerate

   // 1 + tanh or 1 - tanh by the sign of x; tanh is 1 for large samples.
   always_comb begin
      t_sel = side_ff[H_STAGE-1].big ? ONE_Q30[30:0] : div_link[DIV_STEPS].quo;
      h_in  = side_ff[H_STAGE-1].xneg ? (ONE_Q30 - {1'b0, t_sel})
                                      : (ONE_Q30 + {1'b0, t_sel});
   end

   // Half of |x| times h, rounded, then times the gain magnitude, rounded.
   assign g_mul = side_ff[G_STAGE-1].mag * h_ff;
   assign g_sum = {1'b0, g_mul} + G_ROUND;
   assign y_mul = g_ff * gain_mag;
   assign y_sum = {1'b0, y_mul} + Y_HALF;
   assign y_in    = y_sum >> FRAC_BITS;
   assign yneg_in = side_ff[Y_STAGE-1].xneg ^ gain_neg;

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         h_ff    <= h_in;
         g_ff    <= g_sum[DATA_WIDTH+30:31];
         y_ff    <= y_in;
         yneg_ff <= yneg_in;
      end
   end

   // Saturate to the output range and apply the sign.
   always_comb begin
      y_neg_mag = (y_ff > Y_NEG_LIM) ? Y_NEG_LIM[DATA_WIDTH-1:0] : y_ff[DATA_WIDTH-1:0];
      if (yneg_ff) begin
         out_word = DATA_WIDTH'(~y_neg_mag + 1'b1);
      end else begin
         out_word = (y_ff > Y_POS_LIM) ? Y_POS_LIM[DATA_WIDTH-1:0] : y_ff[DATA_WIDTH-1:0];
      end
   end

   // Output register with a skid register behind it.
   assign rsp_take = rsp_valid_ff && rsp_port.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else begin
         if (rsp_take) begin
            rsp_valid_in = 1'b0;
         end
         if (side_ff[Y_STAGE].valid) begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = out_word;
            end else begin
               skid_valid_in = 1'b1;
               skid_data_in  = out_word;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.sample_out = rsp_data_ff;

   // A held result in the skid register always has one waiting in front of it.
   `GTA_ASSERT_SAME(a_skid_behind_rsp, skid_valid_ff, rsp_valid_ff, "skid full, output empty")
   // A finished item meeting a stalled output must land in the skid register.
   `GTA_ASSERT_NEXT(a_skid_catch,
      side_ff[Y_STAGE].valid && !skid_valid_ff && rsp_valid_ff && !rsp_port.ready,
      skid_valid_ff, "finished item lost at a stalled output")
   // The divider's quotient is a tanh value and never exceeds 1.0.
   `GTA_ASSERT_SAME(a_tanh_range, side_ff[H_STAGE-1].valid,
      {1'b0, div_link[DIV_STEPS].quo} <= ONE_Q30, "tanh quotient above 1.0")

endmodule

[tb/gelu_tanh_activation_test.sv]
// Self-checking testbench for the GELU activation block (tanh form, signed Q4.12).
// Depends on gta_pkg, gta_req_if, gta_rsp_if and gelu_tanh_activation from the RTL.
`timescale 1ns / 1ps

module gelu_tanh_activation_test;

   localparam int FRAC_BITS  = 12;
   localparam int DATA_WIDTH = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_STALL = 300;
   localparam int DRAIN_CYCLES = 100;

   typedef logic signed [DATA_WIDTH-1:0] sample_type;

   // Holds the current gain, predicts the GELU of every accepted sample and
   // compares the block's results against those predictions in order.
   class gelu_scoreboard;
      localparam bit [63:0] ONE_Q30   = 64'd1 << 30;
      localparam bit [63:0] K_SQRT2PI = 64'd856722023;
      localparam bit [63:0] K_CUBIC   = 64'd48012366;

      sample_type gain;
      sample_type expected_gelu[$];
      sample_type sample_log[$];
      int         mismatches;
      int         results_seen;

      function new();
         gain = 16'sd4096;
         mismatches = 0;
         results_seen = 0;
      endfunction

      function void set_gain(sample_type g);
         gain = g;
      endfunction

      // tanh of sqrt(2/pi)*(a + 0.044715*a^3) in Q30 for a magnitude a.
      function bit [63:0] tanh_q30(bit [63:0] a);
         bit [63:0] q, s, c, w, u, b, p, e;
         int k;
         if (a >= (64'd4 << FRAC_BITS)) begin
            return ONE_Q30;
         end
         q = a << (30 - FRAC_BITS);
         s = (q * q) >> 30;
         c = (s * (q >> 2)) >> 28;
         w = q + ((K_CUBIC * c) >> 30);
         u = (K_SQRT2PI * w) >> 30;
         b = (u << 1) >> 4;
         // Series for exp(-b), then raised to the sixteenth power.
         p = ONE_Q30;
         for (k = 10; k >= 1; k--) begin
            p = ONE_Q30 - (((b * p) >> 30) / 64'(k));
         end
         e = p;
         repeat (4) e = (e * e) >> 30;
         return ((ONE_Q30 - e) << 30) / (ONE_Q30 + e);
      endfunction

      function sample_type gelu_of(sample_type x);
         bit [63:0] a, gm, t, h, g, y;
         bit        xneg, gneg;
         logic [DATA_WIDTH-1:0] xm, gmag;
         xneg = x[DATA_WIDTH-1];
         gneg = gain[DATA_WIDTH-1];
         xm   = xneg ? (~x + 1'b1) : x;
         gmag = gneg ? (~gain + 1'b1) : gain;
         a  = 64'(xm);
         gm = 64'(gmag);
         t = tanh_q30(a);
         h = xneg ? (ONE_Q30 - t) : (ONE_Q30 + t);
         g = (a * h + ONE_Q30) >> 31;
         y = (g * gm + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
         // Saturate to the signed output range; a zero magnitude stays zero.
         if (xneg != gneg) begin
            if (y > (64'd1 << (DATA_WIDTH - 1))) y = 64'd1 << (DATA_WIDTH - 1);
            return sample_type'(~y[DATA_WIDTH-1:0] + 1'b1);
         end else begin
            if (y > ((64'd1 << (DATA_WIDTH - 1)) - 1)) y = (64'd1 << (DATA_WIDTH - 1)) - 1;
            return sample_type'(y[DATA_WIDTH-1:0]);
         end
      endfunction

      function void note_sample(sample_type x);
         expected_gelu.push_back(gelu_of(x));
         sample_log.push_back(x);
      endfunction

      function void check_result(sample_type y);
         sample_type want, x;
         results_seen++;
         if (expected_gelu.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result: expected none, actual %0d", $time, y);
            return;
         end
         want = expected_gelu.pop_front();
         x = sample_log.pop_front();
         if (y !== want) begin
            mismatches++;
            $display("%0t: sample_out for x=%0d gain=%0d: expected %0d, actual %0d",
                     $time, x, gain, want, y);
         end
      endfunction

      function int pending();
         return expected_gelu.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [DATA_WIDTH-1:0] csr_wr_data;

   gta_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_if ();
   gta_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_if ();

   gelu_tanh_activation #(
      .FRAC_BITS(FRAC_BITS),
      .DATA_WIDTH(DATA_WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_port(req_if),
      .rsp_port(rsp_if),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   gelu_scoreboard gelu_board = new();

   bit idling_on;
   int hold_request;
   bit hold_kick;
   int cycle_count = 0;
   int gain_settings;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Cycle counter and timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, gelu_board.pending());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result receiver: random bursts of back-pressure, plus a long hold when asked.
   initial begin
      int burst_left;
      int hold_left;
      bit kick_seen;
      burst_left = 0;
      hold_left = 0;
      kick_seen = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_kick != kick_seen) begin
            kick_seen = hold_kick;
            hold_left = hold_request;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_if.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(1, 6) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Each result transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         gelu_board.check_result(rsp_if.sample_out);
      end
   end

   // Offers one sample, optionally after an idle burst, and waits for its transfer.
   task automatic send_sample(input sample_type x);
      int gap;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample_in <= x;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      gelu_board.note_sample(x);
      @(negedge clock);
   endtask

   // Stops offering and waits until every predicted result has been seen.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (gelu_board.pending() != 0) @(negedge clock);
   endtask

   // Gain is only written while nothing is in flight.
   task automatic write_gain(input sample_type g);
      csr_wr_en <= 1'b1;
      csr_wr_data <= g;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      gelu_board.set_gain(g);
      gain_settings++;
   endtask

   // Mix of full-range values, the tanh region, the 4.0 threshold and bit patterns.
   function automatic sample_type random_sample();
      int v;
      bit flip;
      flip = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
         0, 1, 2: v = int'($urandom_range(0, 65535)) - 32768;
         3, 4, 5: v = int'($urandom_range(0, 32767)) - 16384;
         6: v = int'($urandom_range(16376, 16392));
         7: v = int'($urandom_range(0, 511)) - 256;
         8: v = 1 << $urandom_range(0, 14);
         default: v = 32767;
      endcase
      if (flip) v = -v;
      return sample_type'(v);
   endfunction

   task automatic random_phase(input sample_type g, input int count, input int hold,
                               input bit mid_drain);
      int n;
      write_gain(g);
      // The receiver picks up the hold request and counts it down itself.
      if (hold > 0) begin
         hold_request = hold;
         hold_kick = !hold_kick;
      end
      for (n = 0; n < count; n++) begin
         if (mid_drain && n == count / 2) begin
            drain_results();
            @(negedge clock);
         end
         send_sample(random_sample());
      end
      drain_results();
   endtask

   initial begin
      sample_type top_gain_set[$];
      sample_type low_gain_set[$];
      sample_type gains[$];
      int ph;

      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.sample_in <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      idling_on = 1'b1;
      hold_request = 0;
      gain_settings = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: largest gain, field extremes, the 4.0 threshold and positive overflow.
      top_gain_set = '{16'sd0, 16'sd1, -16'sd1, 16'sd4096, -16'sd4096, 16'sd16383,
                       16'sd16384, -16'sd16383, -16'sd16384, 16'sd32767, -16'sd32768,
                       16'sd12000};
      write_gain(16'sd32767);
      foreach (top_gain_set[i]) send_sample(top_gain_set[i]);
      drain_results();

      // Directed: most negative gain, negative overflow and a negative zero.
      low_gain_set = '{16'sd32767, 16'sd8192, -16'sd32768, -16'sd20000, 16'sd0,
                       -16'sd1, 16'sd100, -16'sd4096};
      write_gain(-16'sd32768);
      foreach (low_gain_set[i]) send_sample(low_gain_set[i]);
      drain_results();

      // Random phases over a spread of gains; some with a long receiver hold.
      gains = '{16'sd4096, 16'sd0, 16'sd1, -16'sd1, -16'sd4096, 16'sd2048,
                sample_type'($urandom), sample_type'($urandom), sample_type'($urandom)};
      foreach (gains[i]) begin
         random_phase(gains[i], 80, (i == 1 || i == 5) ? LONG_STALL : 0, i == 3);
      end

      // Final stretch at full rate on both sides.
      idling_on = 1'b0;
      random_phase(16'sd4096, 80, 0, 1'b0);

      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d gain settings and %0d results, with stalls on both channels.",
               gain_settings, gelu_board.results_seen);
      $display("Mismatches: %0d, results outstanding: %0d.",
               gelu_board.mismatches, gelu_board.pending());
      if (gelu_board.mismatches == 0 && gelu_board.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
